[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent checks, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/arprr_pkg.sv]
// ----------------------------------------------------------------------------
// arprr_pkg
// types, constants and byte tables of the arp request responder
// ----------------------------------------------------------------------------
package arprr_pkg;

    localparam int CAP_LEN = 42;
    localparam int CAP_AW  = $clog2(CAP_LEN);
    localparam logic [CAP_AW-1:0] LAST_IDX = CAP_AW'(CAP_LEN - 1);

    // tpa occupies the last four captured bytes
    localparam logic [CAP_AW-1:0] TPA_FIRST = CAP_AW'(38);

    localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
    localparam logic [15:0] HTYPE_ETH     = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4    = 16'h0800;
    localparam logic [15:0] OPER_REQUEST  = 16'h0001;
    localparam logic [15:0] OPER_REPLY    = 16'h0002;
    localparam logic [7:0]  HLEN_ETH      = 8'd6;
    localparam logic [7:0]  PLEN_IPV4     = 8'd4;

    localparam logic [47:0] OWN_MAC_RST     = 48'h5254_0012_3402;
    localparam logic [31:0] CLIENT_IP_RST   = 32'h0A00_020F;
    localparam logic [31:0] SUBNET_MASK_RST = 32'hFFFF_FF00;

    localparam int CFG_IW = 2;
    localparam int CFG_DW = 48;
    localparam logic [CFG_IW-1:0] REG_OWN_MAC     = 2'd0;
    localparam logic [CFG_IW-1:0] REG_CLIENT_IP   = 2'd1;
    localparam logic [CFG_IW-1:0] REG_SUBNET_MASK = 2'd2;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } frame_in_t;

    typedef struct packed {
        logic [7:0] reply_byte;
        logic       reply_end;
    } reply_out_t;

    typedef enum logic [1:0] {
        ST_CAPTURE,
        ST_FETCH,
        ST_LOAD,
        ST_SEND
    } state_t;

    // capture address feeding reply byte idx
    function automatic logic [CAP_AW-1:0] src_addr(input logic [CAP_AW-1:0] idx);
        logic [CAP_AW-1:0] a;
        case (idx) inside
            [6'd0:6'd5]:   a = CAP_AW'(idx + 6'd6);
            [6'd28:6'd31]: a = CAP_AW'(idx + 6'd10);
            [6'd32:6'd37]: a = CAP_AW'(idx - 6'd26);
            [6'd38:6'd41]: a = CAP_AW'(idx - 6'd10);
            default:       a = '0;
        endcase
        return a;
    endfunction

    function automatic logic from_store(input logic [CAP_AW-1:0] idx);
        logic r;
        case (idx) inside
            [6'd0:6'd5], [6'd28:6'd41]: r = 1'b1;
            default:                    r = 1'b0;
        endcase
        return r;
    endfunction

    // reply bytes that do not come from the capture store
    function automatic logic [7:0] fixed_byte(input logic [CAP_AW-1:0] idx,
                                              input logic [47:0] mac);
        logic [7:0] b;
        case (idx)
            6'd6,  6'd22: b = mac[47:40];
            6'd7,  6'd23: b = mac[39:32];
            6'd8,  6'd24: b = mac[31:24];
            6'd9,  6'd25: b = mac[23:16];
            6'd10, 6'd26: b = mac[15:8];
            6'd11, 6'd27: b = mac[7:0];
            6'd12: b = ETHERTYPE_ARP[15:8];
            6'd13: b = ETHERTYPE_ARP[7:0];
            6'd14: b = HTYPE_ETH[15:8];
            6'd15: b = HTYPE_ETH[7:0];
            6'd16: b = PTYPE_IPV4[15:8];
            6'd17: b = PTYPE_IPV4[7:0];
            6'd18: b = HLEN_ETH;
            6'd19: b = PLEN_IPV4;
            6'd20: b = OPER_REPLY[15:8];
            6'd21: b = OPER_REPLY[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // header byte check, positions not checked always pass
    function automatic logic hdr_match(input logic [CAP_AW-1:0] pos, input logic [7:0] b);
        logic m;
        case (pos)
            6'd12:   m = (b == ETHERTYPE_ARP[15:8]);
            6'd13:   m = (b == ETHERTYPE_ARP[7:0]);
            6'd14:   m = (b == HTYPE_ETH[15:8]);
            6'd15:   m = (b == HTYPE_ETH[7:0]);
            6'd16:   m = (b == PTYPE_IPV4[15:8]);
            6'd17:   m = (b == PTYPE_IPV4[7:0]);
            6'd20:   m = (b == OPER_REQUEST[15:8]);
            6'd21:   m = (b == OPER_REQUEST[7:0]);
            default: m = 1'b1;
        endcase
        return m;
    endfunction

endpackage

[rtl/arprr_ram.sv]
// ----------------------------------------------------------------------------
// arprr_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module arprr_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 42,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/arp_request_responder_top.sv]
// ----------------------------------------------------------------------------
// arp_request_responder_top
// captures the first 42 bytes of a frame in ram and answers arp requests
// ----------------------------------------------------------------------------
// frame bytes are taken one per cycle while no reply is being sent
// after the final frame beat is taken the fsm passes through fetch and load before the first reply beat is valid
// each reply beat then takes one capture ram read and one output register load
// input is stalled from fetch until the full 42-byte reply has been sent
// reset clears the byte count and state and loads the register defaults, ram is not cleared
`include "assert_macros.svh"

module arp_request_responder_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [arprr_pkg::CFG_IW-1:0]         cfg_index,
    input  logic [arprr_pkg::CFG_DW-1:0]         cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  arprr_pkg::frame_in_t                 in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output arprr_pkg::reply_out_t                out_data
);

    localparam int AW = arprr_pkg::CAP_AW;

    arprr_pkg::state_t     state_reg, state_next;
    logic [AW-1:0]         count_reg, count_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic                  hdr_ok_reg, hdr_ok_next;
    logic [31:0]           tpa_reg, tpa_next;
    arprr_pkg::reply_out_t out_reg, out_next;
    logic [47:0]           own_mac_reg;
    logic [31:0]           client_ip_reg;
    logic [31:0]           subnet_mask_reg;

    logic                  in_acc;
    logic                  out_acc;
    logic                  reply_go;
    logic                  subnet_ok;
    logic                  ram_wr_en;
    logic [AW-1:0]         ram_rd_addr;
    logic [7:0]            ram_rd_data;

    arprr_ram #(
        .WIDTH (8),
        .DEPTH (arprr_pkg::CAP_LEN)
    ) u_capture (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (count_reg),
        .wr_data (in_data.frame_byte),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // capture side: header checks and target address collected as bytes arrive, plus reply index and output byte
    always_comb
    begin
        in_acc    = in_valid && !in_stall;
        out_acc   = out_valid && !out_stall;
        ram_wr_en = in_acc && (count_reg < AW'(arprr_pkg::CAP_LEN));

        hdr_ok_next = ((count_reg == '0) ? 1'b1 : hdr_ok_reg)
                      && arprr_pkg::hdr_match(count_reg, in_data.frame_byte);

        if ((count_reg >= arprr_pkg::TPA_FIRST) && (count_reg < AW'(arprr_pkg::CAP_LEN)))
        begin
            tpa_next = {tpa_reg[23:0], in_data.frame_byte};
        end
        else
        begin
            tpa_next = tpa_reg;
        end

        subnet_ok = ((tpa_next & subnet_mask_reg) == (client_ip_reg & subnet_mask_reg))
                    && (tpa_next != client_ip_reg);

        // frame holds at least 42 bytes once this beat is taken
        reply_go = in_acc && in_data.frame_end && (count_reg >= arprr_pkg::LAST_IDX)
                   && hdr_ok_next && subnet_ok;

        if (in_acc)
        begin
            if (in_data.frame_end)
            begin
                count_next = '0;
            end
            else if (count_reg < AW'(arprr_pkg::CAP_LEN))
            begin
                count_next = AW'(count_reg + 1'b1);
            end
            else
            begin
                count_next = count_reg;
            end
        end
        else
        begin
            count_next = count_reg;
        end

        idx_next = idx_reg;
        if (state_reg == arprr_pkg::ST_FETCH)
        begin
            idx_next = '0;
        end
        else if ((state_reg == arprr_pkg::ST_SEND) && out_acc)
        begin
            idx_next = AW'(idx_reg + 1'b1);
        end

        out_next = out_reg;
        if (state_reg == arprr_pkg::ST_LOAD)
        begin
            out_next.reply_byte = arprr_pkg::from_store(idx_reg) ? ram_rd_data
                                  : arprr_pkg::fixed_byte(idx_reg, own_mac_reg);
            out_next.reply_end  = (idx_reg == arprr_pkg::LAST_IDX);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            arprr_pkg::ST_CAPTURE:
            begin
                if (reply_go)
                begin
                    state_next = arprr_pkg::ST_FETCH;
                end
            end
            arprr_pkg::ST_FETCH:
            begin
                state_next = arprr_pkg::ST_LOAD;
            end
            arprr_pkg::ST_LOAD:
            begin
                state_next = arprr_pkg::ST_SEND;
            end
            arprr_pkg::ST_SEND:
            begin
                if (out_acc)
                begin
                    state_next = (idx_reg == arprr_pkg::LAST_IDX) ? arprr_pkg::ST_CAPTURE
                                 : arprr_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = arprr_pkg::ST_CAPTURE;
            end
        endcase
    end

    // outputs; ram writes happen only in capture, so the reads for a reply never collide with them
    always_comb
    begin
        in_stall  = (state_reg != arprr_pkg::ST_CAPTURE);
        out_valid = (state_reg == arprr_pkg::ST_SEND);
        out_data  = out_reg;
        case (state_reg)
            // read ahead for the next beat while the current one waits
            arprr_pkg::ST_SEND:  ram_rd_addr = arprr_pkg::src_addr(AW'(idx_reg + 1'b1));
            arprr_pkg::ST_FETCH: ram_rd_addr = arprr_pkg::src_addr('0);
            default:             ram_rd_addr = arprr_pkg::src_addr(idx_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= arprr_pkg::ST_CAPTURE;
            count_reg       <= '0;
            idx_reg         <= '0;
            own_mac_reg     <= arprr_pkg::OWN_MAC_RST;
            client_ip_reg   <= arprr_pkg::CLIENT_IP_RST;
            subnet_mask_reg <= arprr_pkg::SUBNET_MASK_RST;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    arprr_pkg::REG_OWN_MAC:     own_mac_reg     <= cfg_data[47:0];
                    arprr_pkg::REG_CLIENT_IP:   client_ip_reg   <= cfg_data[31:0];
                    arprr_pkg::REG_SUBNET_MASK: subnet_mask_reg <= cfg_data[31:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            hdr_ok_reg <= hdr_ok_next;
            tpa_reg    <= tpa_next;
        end
        out_reg <= out_next;
    end

    `ASSERT_ALWAYS(a_count_sat, clk, rst_n, count_reg <= AW'(arprr_pkg::CAP_LEN))
    `ASSERT_IMPLIES(a_emit_count_clear, clk, rst_n,
        state_reg != arprr_pkg::ST_CAPTURE, count_reg == '0)
    `ASSERT_IMPLIES(a_end_on_last, clk, rst_n,
        out_valid, out_data.reply_end == (idx_reg == arprr_pkg::LAST_IDX))
    `ASSERT_NEXT(a_back_to_capture, clk, rst_n,
        out_valid && !out_stall && out_data.reply_end, state_reg == arprr_pkg::ST_CAPTURE)
    `ASSERT_NEXT(a_reply_starts, clk, rst_n,
        reply_go, state_reg == arprr_pkg::ST_FETCH && count_reg == '0)

endmodule
